/* rtl/core/pdc_pkg.sv */
// Shared types, constants and register indexes for the pulse rate and duty capture block.
package pdc_pkg;

    // Field and counter widths
    localparam int CNT_W      = 16;
    localparam int DUTY_W     = 12;
    localparam int SCALE_W    = 12;
    localparam int SUM_W      = CNT_W + 1;
    localparam int PROD_W     = CNT_W + SCALE_W;
    localparam int QUO_W      = DUTY_W;
    localparam int STEP_W     = $clog2(QUO_W);
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 32;

    // Default queue depth between the front and back parts
    localparam int QUEUE_DEPTH_DEF = 2;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_MEASURE_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GATE_TICKS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_LIMIT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_LIMIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_SCALE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_OFFSET  = 3'd5;

    // Register reset values
    localparam logic [CNT_W-1:0]   GATE_TICKS_RST   = 16'd999;
    localparam logic [CNT_W-1:0]   IDLE_LIMIT_RST   = 16'd15000;
    localparam logic [CNT_W-1:0]   PERIOD_LIMIT_RST = 16'd60000;
    localparam logic [SCALE_W-1:0] DUTY_SCALE_RST   = 12'd1100;
    localparam logic [DUTY_W-1:0]  DUTY_OFFSET_RST  = 12'd25;

    // Measurement modes
    localparam logic MODE_PULSE = 1'b0;
    localparam logic MODE_DUTY  = 1'b1;

    // Input kinds
    localparam logic CMD_TICK = 1'b0;

    // Classified operation carried through the queue
    typedef enum logic [1:0] {
        OP_TICK,
        OP_PULSE,
        OP_RISE,
        OP_FALL
    } op_t;

    // Queue head as seen by the back part
    typedef struct packed {
        logic valid;
        op_t  op;
    } que_t;

    // Configuration register set
    typedef struct packed {
        logic               measure_mode;
        logic [CNT_W-1:0]   gate_ticks;
        logic [CNT_W-1:0]   idle_limit;
        logic [CNT_W-1:0]   period_limit;
        logic [SCALE_W-1:0] duty_scale;
        logic [DUTY_W-1:0]  duty_offset;
    } cfg_t;

    // Divider request and response
    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] hi;
        logic [CNT_W-1:0] lo;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DUTY_W-1:0] duty;
    } div_rsp_t;

    // Back part sequencer states
    typedef enum logic [1:0] {
        B_IDLE,
        B_DIV,
        B_EMIT
    } back_state_t;

    // Divider states
    typedef enum logic [1:0] {
        D_IDLE,
        D_RUN,
        D_FIN
    } div_state_t;

endpackage

/* rtl/core/pdc_front.sv */
// Front part: accepts input items, classifies them and queues them for the back part.
module pdc_front
    import pdc_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    input  logic s_tuser,
    input  logic pin_level,
    input  logic measure_mode,
    output que_t head,
    input  logic pop
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    op_t              slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic             push;
    logic             do_pop;
    op_t              op_in;

    // Classify the incoming item
    always_comb
    begin
        if (s_tuser == CMD_TICK)
        begin
            op_in = OP_TICK;
        end
        else if (measure_mode == MODE_PULSE)
        begin
            op_in = OP_PULSE;
        end
        else if (pin_level)
        begin
            op_in = OP_RISE;
        end
        else
        begin
            op_in = OP_FALL;
        end
    end

    assign s_tready   = (fill_reg != FILL_W'(QUEUE_DEPTH));
    assign push       = s_tvalid && s_tready;
    assign head.valid = (fill_reg != '0);
    assign head.op    = slot_reg[rd_ptr_reg];
    assign do_pop     = pop && head.valid;

    // Advance pointers and fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (!push && do_pop)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Store the classified item
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= op_in;
        end
    end

endmodule

/* rtl/core/pdc_div.sv */
// Iterative duty divider: high*scale/(high+low), one quotient bit a cycle, then offset and clamp.
module pdc_div
    import pdc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  div_req_t           req,
    input  logic [SCALE_W-1:0] duty_scale,
    input  logic [DUTY_W-1:0]  duty_offset,
    output div_rsp_t           rsp
);

    div_state_t        state_reg;
    div_state_t        state_next;
    logic [PROD_W-1:0] rem_reg;
    logic [PROD_W-1:0] rem_next;
    logic [PROD_W-1:0] dsh_reg;
    logic [PROD_W-1:0] dsh_next;
    logic [QUO_W-1:0]  quo_reg;
    logic [QUO_W-1:0]  quo_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              zero_reg;
    logic              zero_next;
    logic [SUM_W-1:0]  sum;
    logic              ge;

    assign sum = SUM_W'(req.hi) + SUM_W'(req.lo);
    assign ge  = (rem_reg >= dsh_reg);

    // Sequence the product, the restoring steps and the final clamp
    always_comb
    begin
        state_next = state_reg;
        rem_next   = rem_reg;
        dsh_next   = dsh_reg;
        quo_next   = quo_reg;
        step_next  = step_reg;
        zero_next  = zero_reg;
        rsp.done   = 1'b0;
        rsp.duty   = '0;
        unique case (state_reg)
            D_IDLE:
            begin
                if (req.start)
                begin
                    rem_next   = PROD_W'(req.hi) * PROD_W'(duty_scale);
                    dsh_next   = {sum, (QUO_W - 1)'(0)};
                    quo_next   = '0;
                    step_next  = STEP_W'(QUO_W - 1);
                    zero_next  = (sum == '0);
                    state_next = D_RUN;
                end
            end
            D_RUN:
            begin
                if (ge)
                begin
                    rem_next = rem_reg - dsh_reg;
                end
                quo_next = {quo_reg[QUO_W-2:0], ge};
                dsh_next = dsh_reg >> 1;
                if (step_reg == '0)
                begin
                    state_next = D_FIN;
                end
                else
                begin
                    step_next = step_reg - 1'b1;
                end
            end
            D_FIN:
            begin
                rsp.done = 1'b1;
                if (!zero_reg && (quo_reg > duty_offset))
                begin
                    rsp.duty = quo_reg - duty_offset;
                end
                state_next = D_IDLE;
            end
            default:
            begin
                state_next = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Hold the working values
    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        dsh_reg  <= dsh_next;
        quo_reg  <= quo_next;
        step_reg <= step_next;
        zero_reg <= zero_next;
    end

endmodule

/* rtl/core/pdc_back.sv */
// Back part: carries out queued items on the counters and latches and drives the result register.
module pdc_back
    import pdc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  que_t                  head,
    output logic                  pop,
    input  cfg_t                  cfg,
    output div_req_t              div_req,
    input  div_rsp_t              div_rsp,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [CNT_W-1:0]      pulse_rate,
    output logic [DUTY_W-1:0]     duty_value
);

    back_state_t       state_reg;
    back_state_t       state_next;
    logic [CNT_W-1:0]  period_count_reg;
    logic [CNT_W-1:0]  period_count_next;
    logic [CNT_W-1:0]  idle_count_reg;
    logic [CNT_W-1:0]  idle_count_next;
    logic [CNT_W-1:0]  gate_count_reg;
    logic [CNT_W-1:0]  gate_count_next;
    logic [CNT_W-1:0]  edge_count_reg;
    logic [CNT_W-1:0]  edge_count_next;
    logic [CNT_W-1:0]  low_time_reg;
    logic [CNT_W-1:0]  low_time_next;
    logic [CNT_W-1:0]  rate_latch_reg;
    logic [CNT_W-1:0]  rate_latch_next;
    logic [DUTY_W-1:0] duty_latch_reg;
    logic [DUTY_W-1:0] duty_latch_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [CNT_W-1:0]  out_rate_reg;
    logic [CNT_W-1:0]  out_rate_next;
    logic [DUTY_W-1:0] out_duty_reg;
    logic [DUTY_W-1:0] out_duty_next;
    logic              out_free;
    logic              load;
    logic [SUM_W-1:0]  period_inc;
    logic [SUM_W-1:0]  idle_inc;
    logic [SUM_W-1:0]  gate_inc;

    assign out_free   = !out_valid_reg || m_tready;
    assign pop        = (state_reg == B_IDLE) && head.valid && out_free;
    assign period_inc = SUM_W'(period_count_reg) + 1'b1;
    assign idle_inc   = SUM_W'(idle_count_reg) + 1'b1;
    assign gate_inc   = SUM_W'(gate_count_reg) + 1'b1;

    assign m_tvalid   = out_valid_reg;
    assign pulse_rate = out_rate_reg;
    assign duty_value = out_duty_reg;

    // Carry out the head item and sequence the duty division
    always_comb
    begin
        state_next        = state_reg;
        period_count_next = period_count_reg;
        idle_count_next   = idle_count_reg;
        gate_count_next   = gate_count_reg;
        edge_count_next   = edge_count_reg;
        low_time_next     = low_time_reg;
        rate_latch_next   = rate_latch_reg;
        duty_latch_next   = duty_latch_reg;
        div_req.start     = 1'b0;
        div_req.hi        = period_count_reg;
        div_req.lo        = low_time_reg;
        load              = 1'b0;
        unique case (state_reg)
            B_IDLE:
            begin
                if (pop)
                begin
                    case (head.op)
                        OP_TICK:
                        begin
                            load = 1'b1;
                            if (period_inc > SUM_W'(cfg.period_limit))
                            begin
                                period_count_next = '0;
                                duty_latch_next   = '0;
                            end
                            else
                            begin
                                period_count_next = period_inc[CNT_W-1:0];
                            end
                            if (idle_inc > SUM_W'(cfg.idle_limit))
                            begin
                                idle_count_next = '0;
                                duty_latch_next = '0;
                                rate_latch_next = '0;
                            end
                            else
                            begin
                                idle_count_next = idle_inc[CNT_W-1:0];
                            end
                            if (gate_inc >= SUM_W'(cfg.gate_ticks))
                            begin
                                rate_latch_next = edge_count_reg;
                                edge_count_next = '0;
                                gate_count_next = '0;
                            end
                            else
                            begin
                                gate_count_next = gate_inc[CNT_W-1:0];
                            end
                        end
                        OP_PULSE:
                        begin
                            load            = 1'b1;
                            idle_count_next = '0;
                            if (edge_count_reg != '1)
                            begin
                                edge_count_next = edge_count_reg + 1'b1;
                            end
                        end
                        OP_RISE:
                        begin
                            load              = 1'b1;
                            idle_count_next   = '0;
                            low_time_next     = period_count_reg;
                            period_count_next = '0;
                        end
                        default:
                        begin
                            // Falling edge: hand the high time to the divider and start it
                            idle_count_next   = '0;
                            period_count_next = '0;
                            div_req.start     = 1'b1;
                            state_next        = B_DIV;
                        end
                    endcase
                end
            end
            B_DIV:
            begin
                if (div_rsp.done)
                begin
                    duty_latch_next = div_rsp.duty;
                    state_next      = B_EMIT;
                end
            end
            B_EMIT:
            begin
                if (out_free)
                begin
                    load       = 1'b1;
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // Update the result register
    always_comb
    begin
        out_valid_next = out_valid_reg && !m_tready;
        out_rate_next  = out_rate_reg;
        out_duty_next  = out_duty_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            out_rate_next  = rate_latch_next;
            out_duty_next  = duty_latch_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= B_IDLE;
            period_count_reg <= '0;
            idle_count_reg   <= '0;
            gate_count_reg   <= '0;
            edge_count_reg   <= '0;
            low_time_reg     <= '0;
            rate_latch_reg   <= '0;
            duty_latch_reg   <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            period_count_reg <= period_count_next;
            idle_count_reg   <= idle_count_next;
            gate_count_reg   <= gate_count_next;
            edge_count_reg   <= edge_count_next;
            low_time_reg     <= low_time_next;
            rate_latch_reg   <= rate_latch_next;
            duty_latch_reg   <= duty_latch_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // Hold the result payload
    always_ff @(posedge clk)
    begin
        out_rate_reg <= out_rate_next;
        out_duty_reg <= out_duty_next;
    end

endmodule

/* rtl/core/pulse_rate_and_duty_capture.sv */
// Top level of the pulse rate and duty capture block: configuration registers and part wiring.
//
// Input items arrive on the s_ channel: s_tuser is the kind (0 timer tick, 1 sensor edge)
// and s_tdata[0] the pin level after an edge. Every item yields one result item on the
// m_ channel carrying the latched pulse rate and duty value.
// User writes configuration on cfg_we/cfg_index/cfg_data only with no item in flight; unenforced.
// The front part classifies each item against the measure mode and queues it
// (QUEUE_DEPTH entries); the back part carries it out on the counters and latches.
// Ticks, pulse edges and rising edges are registered in the queue, then in the result register
// that drives m_tvalid; a steady rate of one item a cycle is possible while m_tready stays high.
// A falling edge in duty mode runs the iterative divider, one quotient bit a cycle over
// 12 bits; after that item is accepted, the divider is started, forms the quotient bits, then
// offsets and clamps the result, and B_EMIT loads the result register that drives m_tvalid.
// The result register parts the two sides: when m_tready is low the result is held and
// the queue keeps taking items until it is full, then s_tready falls.
// Reset clears all counters and latches and loads the documented register defaults.
module pulse_rate_and_duty_capture
    import pdc_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // [0] pin_level, [7:1] zero
    input  logic                  s_tuser,   // [0] cmd
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // [15:0] pulse_rate, [27:16] duty_value, [31:28] zero
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t              cfg_reg;
    cfg_t              cfg_next;
    que_t              head;
    logic              pop;
    div_req_t          div_req;
    div_rsp_t          div_rsp;
    logic [CNT_W-1:0]  pulse_rate;
    logic [DUTY_W-1:0] duty_value;

    // Decode configuration writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MEASURE_MODE: cfg_next.measure_mode = cfg_data[0];
                CFG_GATE_TICKS:   cfg_next.gate_ticks   = cfg_data;
                CFG_IDLE_LIMIT:   cfg_next.idle_limit   = cfg_data;
                CFG_PERIOD_LIMIT: cfg_next.period_limit = cfg_data;
                CFG_DUTY_SCALE:   cfg_next.duty_scale   = cfg_data[SCALE_W-1:0];
                CFG_DUTY_OFFSET:  cfg_next.duty_offset  = cfg_data[DUTY_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.measure_mode <= MODE_PULSE;
            cfg_reg.gate_ticks   <= GATE_TICKS_RST;
            cfg_reg.idle_limit   <= IDLE_LIMIT_RST;
            cfg_reg.period_limit <= PERIOD_LIMIT_RST;
            cfg_reg.duty_scale   <= DUTY_SCALE_RST;
            cfg_reg.duty_offset  <= DUTY_OFFSET_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    pdc_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tuser      (s_tuser),
        .pin_level    (s_tdata[0]),
        .measure_mode (cfg_reg.measure_mode),
        .head         (head),
        .pop          (pop)
    );

    pdc_div u_div (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (div_req),
        .duty_scale  (cfg_reg.duty_scale),
        .duty_offset (cfg_reg.duty_offset),
        .rsp         (div_rsp)
    );

    pdc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .pop        (pop),
        .cfg        (cfg_reg),
        .div_req    (div_req),
        .div_rsp    (div_rsp),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .pulse_rate (pulse_rate),
        .duty_value (duty_value)
    );

    // Pack the result item
    assign m_tdata = {(OUT_DATA_W - CNT_W - DUTY_W)'(0), duty_value, pulse_rate};

endmodule
